### rtl/steered_array_channel_combiner_assert.svh
// ----------------------------------------------------------------------------
// steered array channel combiner assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef STEERED_ARRAY_CHANNEL_COMBINER_ASSERT_SVH
`define STEERED_ARRAY_CHANNEL_COMBINER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent ends
`define SAC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sac assertion failed");

// consequent checked in the cycle after the antecedent
`define SAC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sac assertion failed");

`endif

### rtl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// types, constants and tables shared by the steered array combiner
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int IN_CH        = 4;
  localparam int CHANNELS_DEF = 4;
  localparam int LANE_W       = 3;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 50;
  localparam int WGT_W    = 32;
  localparam int TRIG_W   = 34;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int ANGLE_W  = 17;
  localparam int DIST_W   = 24;
  localparam int FREQ_W   = 32;
  localparam int AMP_W    = 31;

  localparam int DIV_N        = 60;
  localparam int DIV_D        = 58;
  localparam int CORDIC_STEPS = 30;

  // register map, index = paddr word address
  localparam logic [ADDR_W-3:0] REG_ANGLE = 3'd0;
  localparam logic [ADDR_W-3:0] REG_PATH  = 3'd1;
  localparam logic [ADDR_W-3:0] REG_FLOOR = 3'd2;
  localparam logic [ADDR_W-3:0] REG_FREQ  = 3'd3;
  localparam logic [ADDR_W-3:0] REG_TURN  = 3'd4;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic [4:0]               CORDIC_LAST     = 5'(CORDIC_STEPS - 1);

  // speed of light times round(2^32 / (4 pi))
  localparam logic [DIV_N-1:0] PATH_LOSS_NUM = 60'd102463857147744204;

  // degrees to binary angle: (m * 2^21 + 22) / 45 split as
  // m * 46603 + (17 m + 22) / 45, the small part by reciprocal multiply
  localparam logic [15:0] THETA_HI_MUL = 16'd46603;
  localparam logic [4:0]  THETA_LO_MUL = 5'd17;
  localparam logic [20:0] THETA_RND    = 21'd22;
  localparam logic [21:0] THETA_RECIP  = 22'd2982617;
  localparam int          THETA_SHIFT  = 27;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [WGT_W-1:0]    wgt_t;
  typedef logic signed [TRIG_W-1:0]   trig_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]         path_mm;
    logic [DIST_W-1:0]         floor_mm;
    logic [FREQ_W-1:0]         carrier;
    logic                      full_turn;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [LANE_W-1:0] idx;
    wgt_t              re;
    wgt_t              im;
  } wgt_wr_t;

  // arctangent of 2^-i as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/sac_if.sv
// ----------------------------------------------------------------------------
// sac_if
// request and result channels of the steered array combiner
// ----------------------------------------------------------------------------
interface sac_in_if import sac_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t ch0_re;
  sample_t ch0_im;
  sample_t ch1_re;
  sample_t ch1_im;
  sample_t ch2_re;
  sample_t ch2_im;
  sample_t ch3_re;
  sample_t ch3_im;

  modport source (
    output valid, ch0_re, ch0_im, ch1_re, ch1_im, ch2_re, ch2_im, ch3_re, ch3_im,
    input  ready
  );
  modport sink (
    input  valid, ch0_re, ch0_im, ch1_re, ch1_im, ch2_re, ch2_im, ch3_re, ch3_im,
    output ready
  );
endinterface

interface sac_out_if import sac_pkg::*; ();
  logic valid;
  logic ready;
  sum_t sum_re;
  sum_t sum_im;

  modport source (output valid, sum_re, sum_im, input ready);
  modport sink (input valid, sum_re, sum_im, output ready);
endinterface

### rtl/sac_div.sv
// ----------------------------------------------------------------------------
// sac_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sac_div import sac_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_N-1:0] dividend_i,
  input  logic [DIV_D-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_N-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIV_N);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_N - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_N-1:0] dvd_q, dvd_d;
  logic [DIV_D-1:0] rem_q, rem_d;
  logic [DIV_D-1:0] dvs_q;
  logic [DIV_D:0]   trial;
  logic [DIV_D:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, dvd_q[DIV_N-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
    // quotient bits enter at the bottom as the dividend leaves the top
    dvd_d = {dvd_q[DIV_N-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

### rtl/sac_cordic.sv
// ----------------------------------------------------------------------------
// sac_cordic
// iterative rotation cordic, binary angle in, cosine and sine out in q4.30
// ----------------------------------------------------------------------------
module sac_cordic import sac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] angle_i,
  output logic        done_o,
  output trig_t       cos_o,
  output trig_t       sin_o
);

  localparam trig_t QUARTER   = trig_t'(64'sd1073741824);
  localparam trig_t HALF_TURN = trig_t'(64'sd2147483648);

  logic       busy_q;
  logic       done_q;
  logic [4:0] cnt_q;
  logic       flip_q;
  trig_t      x_q, y_q, z_q;
  trig_t      a0, z0;
  logic       flip0;
  trig_t      dx, dy, da;

  always_comb begin
    a0 = TRIG_W'($signed(angle_i));
    // fold into the right half plane, undone by negating the result
    if (a0 > QUARTER) begin
      z0    = a0 - HALF_TURN;
      flip0 = 1'b1;
    end else if (a0 < -QUARTER) begin
      z0    = a0 + HALF_TURN;
      flip0 = 1'b1;
    end else begin
      z0    = a0;
      flip0 = 1'b0;
    end
    dx = y_q >>> cnt_q;
    dy = x_q >>> cnt_q;
    da = trig_t'({2'b00, atan_bam(cnt_q)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CORDIC_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CORDIC_GAIN_INV;
      y_q    <= '0;
      z_q    <= z0;
      flip_q <= flip0;
    end else if (busy_q) begin
      if (!z_q[TRIG_W-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - da;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + da;
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

### rtl/sac_wgen.sv
// ----------------------------------------------------------------------------
// sac_wgen
// weight sequencer: path loss amplitude and per-channel steering phase
// ----------------------------------------------------------------------------
module sac_wgen import sac_pkg::*; #(
  parameter int LANES = CHANNELS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    restart_i,
  output logic    busy_o,
  output wgt_wr_t wr_o
);

  localparam int KW     = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int PROD_W = WGT_W + TRIG_W;
  localparam int STK_W  = TRIG_W + KW + 1;
  localparam logic [KW-1:0] K_LAST = KW'(LANES - 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_TDIV    = 4'd2;
  localparam logic [3:0] S_AMUL    = 4'd3;
  localparam logic [3:0] S_ALAUNCH = 4'd4;
  localparam logic [3:0] S_ADIV    = 4'd5;
  localparam logic [3:0] S_TLAUNCH = 4'd6;
  localparam logic [3:0] S_TCOR    = 4'd7;
  localparam logic [3:0] S_PHASE   = 4'd8;
  localparam logic [3:0] S_PLAUNCH = 4'd9;
  localparam logic [3:0] S_PCOR    = 4'd10;
  localparam logic [3:0] S_WRITE   = 4'd11;

  logic [3:0]         state_q, state_d;
  logic [KW-1:0]      k_q;
  logic [31:0]        theta_q;
  logic [31:0]        th_hi_q;
  logic [20:0]        th_lo_q;
  logic [DIV_D-1:0]   den_q;
  logic [AMP_W-1:0]   amp_q;
  trig_t              st_q;
  logic [31:0]        ph_q;
  logic signed [PROD_W-1:0] prod_re_q, prod_im_q;

  logic [ANGLE_W-1:0] mag;
  logic [DIST_W-1:0]  fl, reach_mm;
  logic [32:0]        th_hi;
  logic [20:0]        th_lo;
  logic [42:0]        th_prod;
  logic [31:0]        th_sum;
  logic               div_start, div_done;
  logic [DIV_N-1:0]   div_dvd, div_quot;
  logic [DIV_D-1:0]   div_dvs;
  logic               cor_start, cor_done;
  logic [31:0]        cor_angle;
  trig_t              cor_cos, cor_sin;
  logic signed [STK_W-1:0] stk;
  logic signed [WGT_W:0]   amp_s;

  function automatic wgt_t sat_wgt(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0]  r;
    logic signed [PROD_W-31:0] s;
    wgt_t                      w;
    r = p + PROD_W'(64'sd536870912);
    s = r[PROD_W-1:30];
    if (!s[PROD_W-31] && (|s[PROD_W-32:WGT_W-1]))
      w = {1'b0, {(WGT_W-1){1'b1}}};
    else if (s[PROD_W-31] && !(&s[PROD_W-32:WGT_W-1]))
      w = {1'b1, {(WGT_W-1){1'b0}}};
    else
      w = s[WGT_W-1:0];
    return w;
  endfunction

  sac_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  sac_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  always_comb begin
    mag      = cfg_i.angle[ANGLE_W-1] ? (~cfg_i.angle + 1'b1) : cfg_i.angle;
    fl       = (cfg_i.floor_mm == '0) ? DIST_W'(1) : cfg_i.floor_mm;
    reach_mm = (cfg_i.path_mm > fl) ? cfg_i.path_mm : fl;
    stk      = st_q * $signed({1'b0, k_q});
    amp_s    = $signed({2'b00, amp_q});
    th_hi    = 33'(mag) * 33'(THETA_HI_MUL);
    th_lo    = 21'(mag) * 21'(THETA_LO_MUL) + THETA_RND;
    th_prod  = 43'(th_lo_q) * 43'(THETA_RECIP);
    th_sum   = th_hi_q + {16'b0, th_prod[42:THETA_SHIFT]};

    div_start = 1'b0;
    div_dvd   = PATH_LOSS_NUM + DIV_N'(den_q[DIV_D-1:1]);
    div_dvs   = den_q;
    cor_start = 1'b0;
    cor_angle = theta_q;
    state_d   = state_q;
    case (state_q)
      S_IDLE: ;
      S_INIT:  state_d = S_TDIV;
      S_TDIV:  state_d = S_AMUL;
      S_AMUL:  state_d = S_ALAUNCH;
      S_ALAUNCH: begin
        // zero carrier gives zero amplitude, no division
        if (cfg_i.carrier == '0) begin
          state_d = S_TLAUNCH;
        end else begin
          div_start = 1'b1;
          state_d   = S_ADIV;
        end
      end
      S_ADIV: begin
        if (div_done) state_d = S_TLAUNCH;
      end
      S_TLAUNCH: begin
        cor_start = 1'b1;
        state_d   = S_TCOR;
      end
      S_TCOR: begin
        if (cor_done) state_d = S_PHASE;
      end
      S_PHASE: state_d = S_PLAUNCH;
      S_PLAUNCH: begin
        cor_start = 1'b1;
        cor_angle = ph_q;
        state_d   = S_PCOR;
      end
      S_PCOR: begin
        if (cor_done) state_d = S_WRITE;
      end
      S_WRITE: begin
        state_d = (k_q == K_LAST) ? S_IDLE : S_PHASE;
      end
      default: state_d = S_INIT;
    endcase
    if (restart_i) state_d = S_INIT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_TCOR && cor_done) k_q <= '0;
      else if (state_q == S_WRITE && k_q != K_LAST) k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_INIT) begin
      th_hi_q <= th_hi[31:0];
      th_lo_q <= th_lo;
    end
    if (state_q == S_TDIV)
      theta_q <= cfg_i.angle[ANGLE_W-1] ? (32'd0 - th_sum) : th_sum;
    if (state_q == S_AMUL)
      den_q <= {(FREQ_W+DIST_W)'(cfg_i.carrier) * (FREQ_W+DIST_W)'(reach_mm), 2'b00};
    if (state_q == S_ALAUNCH && cfg_i.carrier == '0)
      amp_q <= '0;
    if (state_q == S_ADIV && div_done)
      amp_q <= (|div_quot[DIV_N-1:AMP_W]) ? {AMP_W{1'b1}} : div_quot[AMP_W-1:0];
    if (state_q == S_TCOR && cor_done)
      st_q <= cor_sin;
    // phase step is a full or half turn per unit of sine
    if (state_q == S_PHASE)
      ph_q <= cfg_i.full_turn ? {stk[29:0], 2'b00} : {stk[30:0], 1'b0};
    if (state_q == S_PCOR && cor_done) begin
      prod_re_q <= PROD_W'(amp_s * cor_cos);
      prod_im_q <= PROD_W'(amp_s * cor_sin);
    end
  end

  assign busy_o   = state_q != S_IDLE;
  assign wr_o.valid = state_q == S_WRITE;
  assign wr_o.idx   = LANE_W'(k_q);
  assign wr_o.re    = sat_wgt(prod_re_q);
  assign wr_o.im    = sat_wgt(prod_im_q);

endmodule

### rtl/sac_cell.sv
// ----------------------------------------------------------------------------
// sac_cell
// one channel of the combiner: holds its weight, adds its product to the sum
// ----------------------------------------------------------------------------
module sac_cell import sac_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  wgt_wr_t wr_i,
  input  logic    valid_i,
  input  sample_t re_i [IN_CH],
  input  sample_t im_i [IN_CH],
  input  sum_t    acc_re_i,
  input  sum_t    acc_im_i,
  output logic    valid_o,
  output sample_t re_o [IN_CH],
  output sample_t im_o [IN_CH],
  output sum_t    acc_re_o,
  output sum_t    acc_im_o
);

  localparam int P_W = WGT_W + SAMPLE_W;

  logic    valid_q;
  wgt_t    w_re_q, w_im_q;
  sample_t re_q [IN_CH];
  sample_t im_q [IN_CH];
  sum_t    acc_re_q, acc_im_q;
  logic signed [P_W-1:0] p_ra, p_ib, p_rb, p_ia;
  sum_t    acc_re_d, acc_im_d;

  always_comb begin
    p_ra = w_re_q * re_i[IDX];
    p_ib = w_im_q * im_i[IDX];
    p_rb = w_re_q * im_i[IDX];
    p_ia = w_im_q * re_i[IDX];
    acc_re_d = acc_re_i + SUM_W'(p_ra) - SUM_W'(p_ib);
    acc_im_d = acc_im_i + SUM_W'(p_rb) + SUM_W'(p_ia);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid && wr_i.idx == LANE_W'(IDX)) begin
      w_re_q <= wr_i.re;
      w_im_q <= wr_i.im;
    end
    if (en_i) begin
      re_q     <= re_i;
      im_q     <= im_i;
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  assign valid_o  = valid_q;
  assign re_o     = re_q;
  assign im_o     = im_q;
  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule

### rtl/steered_array_channel_combiner.sv
// ----------------------------------------------------------------------------
// steered_array_channel_combiner
// weights each channel sample by a steering coefficient and sums the channels
//
//   port        dir  handshake             carries
//   in_ch_i     in   valid/ready           ch0..ch3 complex samples, q1.15
//   out_ch_o    out  valid/ready           sum_re, sum_im, 2^45 per unit
//   apb         in   psel/penable/pwrite   steering and path loss registers
//
// one request per cycle; a result passes through one registered cell of the
// chain per channel used
// after reset and after each register write the sequencer rebuilds the
// weights with one division, skipped for a zero carrier, and 30-step cordic
// passes; no request is taken meanwhile
// an output stall holds the whole chain
// ----------------------------------------------------------------------------
module steered_array_channel_combiner import sac_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sac_in_if.sink            in_ch_i,
  sac_out_if.source         out_ch_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int LANES = (CHANNELS < IN_CH) ? CHANNELS : IN_CH;

  logic signed [ANGLE_W-1:0] angle_q;
  logic [DIST_W-1:0]         path_q;
  logic [DIST_W-1:0]         floor_q;
  logic [FREQ_W-1:0]         carrier_q;
  logic                      turn_q;

  logic              wr_en;
  logic [ADDR_W-3:0] reg_idx;
  logic              reg_hit;
  cfg_t              cfg;
  wgt_wr_t           wgt_wr;
  logic              busy;
  logic              en;

  logic    valid_c  [LANES+1];
  sample_t re_c     [LANES+1][IN_CH];
  sample_t im_c     [LANES+1][IN_CH];
  sum_t    acc_re_c [LANES+1];
  sum_t    acc_im_c [LANES+1];

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    reg_hit = 1'b1;
    prdata  = '0;
    case (reg_idx)
      REG_ANGLE: prdata = DATA_W'(angle_q);
      REG_PATH:  prdata = DATA_W'(path_q);
      REG_FLOOR: prdata = DATA_W'(floor_q);
      REG_FREQ:  prdata = carrier_q;
      REG_TURN:  prdata = DATA_W'(turn_q);
      default:   reg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q   <= '0;
      path_q    <= DIST_W'(1000);
      floor_q   <= DIST_W'(1);
      carrier_q <= FREQ_W'(28000000);
      turn_q    <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ANGLE: angle_q   <= pwdata[ANGLE_W-1:0];
        REG_PATH:  path_q    <= pwdata[DIST_W-1:0];
        REG_FLOOR: floor_q   <= pwdata[DIST_W-1:0];
        REG_FREQ:  carrier_q <= pwdata[FREQ_W-1:0];
        REG_TURN:  turn_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign cfg.angle     = angle_q;
  assign cfg.path_mm   = path_q;
  assign cfg.floor_mm  = floor_q;
  assign cfg.carrier   = carrier_q;
  assign cfg.full_turn = turn_q;

  sac_wgen #(.LANES(LANES)) u_wgen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (wr_en && reg_hit),
    .busy_o    (busy),
    .wr_o      (wgt_wr)
  );

  // chain moves whenever the output register is free or being drained
  assign en            = !valid_c[LANES] || out_ch_o.ready;
  assign in_ch_i.ready = en && !busy;

  assign valid_c[0]    = in_ch_i.valid && !busy;
  assign re_c[0][0]    = in_ch_i.ch0_re;
  assign im_c[0][0]    = in_ch_i.ch0_im;
  assign re_c[0][1]    = in_ch_i.ch1_re;
  assign im_c[0][1]    = in_ch_i.ch1_im;
  assign re_c[0][2]    = in_ch_i.ch2_re;
  assign im_c[0][2]    = in_ch_i.ch2_im;
  assign re_c[0][3]    = in_ch_i.ch3_re;
  assign im_c[0][3]    = in_ch_i.ch3_im;
  assign acc_re_c[0]   = '0;
  assign acc_im_c[0]   = '0;

  for (genvar g = 0; g < LANES; g++) begin : g_cell
    sac_cell #(.IDX(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .wr_i     (wgt_wr),
      .valid_i  (valid_c[g]),
      .re_i     (re_c[g]),
      .im_i     (im_c[g]),
      .acc_re_i (acc_re_c[g]),
      .acc_im_i (acc_im_c[g]),
      .valid_o  (valid_c[g+1]),
      .re_o     (re_c[g+1]),
      .im_o     (im_c[g+1]),
      .acc_re_o (acc_re_c[g+1]),
      .acc_im_o (acc_im_c[g+1])
    );
  end

  assign out_ch_o.valid  = valid_c[LANES];
  assign out_ch_o.sum_re = acc_re_c[LANES];
  assign out_ch_o.sum_im = acc_im_c[LANES];

endmodule

### rtl/sac_checker.sv
// ----------------------------------------------------------------------------
// sac_checker
// port-level checks on the steered array combiner, bound to the top level
// ----------------------------------------------------------------------------
`include "steered_array_channel_combiner_assert.svh"

module sac_checker import sac_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  sac_in_if.sink           in_ch_i,
  sac_out_if.source        out_ch_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              pready
);

  logic [ADDR_W-3:0] idx;
  logic              cfg_hit;
  logic              path_wr;
  logic              path_rd;
  logic              out_stall;

  assign idx     = paddr[ADDR_W-1:2];
  assign cfg_hit = psel && penable && pwrite && pready &&
                   (idx == REG_ANGLE || idx == REG_PATH || idx == REG_FLOOR ||
                    idx == REG_FREQ || idx == REG_TURN);
  assign path_wr   = psel && penable && pwrite && pready && idx == REG_PATH;
  assign path_rd   = psel && !pwrite && idx == REG_PATH;
  assign out_stall = out_ch_o.valid && !out_ch_o.ready;

  // a held result stays offered and unchanged
  `SAC_ASSERT_NEXT(a_out_hold_valid, clk_i, rst_ni, out_stall, out_ch_o.valid)
  `SAC_ASSERT_NEXT(a_out_hold_data, clk_i, rst_ni, out_stall, $stable(out_ch_o.sum_re) && $stable(out_ch_o.sum_im))

  // weights are rebuilt after any register write, so no request is taken
  `SAC_ASSERT_NEXT(a_cfg_blocks_input, clk_i, rst_ni, cfg_hit, !in_ch_i.ready)

  // distance register reads back what was written
  `SAC_ASSERT_NOW(a_path_readback, clk_i, rst_ni, path_wr ##1 path_rd, prdata[31:24] == 8'd0 && prdata[23:0] == $past(pwdata[23:0]))

endmodule

bind steered_array_channel_combiner sac_checker u_sac_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_ch_i  (in_ch_i),
  .out_ch_o (out_ch_o),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);

### bench/testbench.sv
// ----------------------------------------------------------------------------
// steered array combiner testbench
// drives multi-channel sample requests through several steering and path
// loss settings and checks each weighted sum against an in-bench predictor
// ----------------------------------------------------------------------------
module testbench;
  import sac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NCH        = 4;
  localparam int  CYCLE_CAP  = 400000;
  localparam int  SETTLE     = NCH + 12;
  localparam int  PHASE_REQS = 168;

  typedef struct { sample_t s [2*NCH]; } samples_t;
  typedef struct { sum_t re; sum_t im; } beam_sum_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sac_in_if  in_ch ();
  sac_out_if out_ch ();

  steered_array_channel_combiner #(.CHANNELS(NCH)) DUT (
    .clk_i, .rst_ni, .in_ch_i(in_ch), .out_ch_o(out_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  samples_t  pending_reqs [$];
  beam_sum_t expected_sums [$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycles = 0;
  bit        calm = 1'b0;

  // shadow of the register file and the weights it yields
  logic signed [ANGLE_W-1:0] angle_q88 = '0;
  logic [DIST_W-1:0]         path_mm = 24'd1000;
  logic [DIST_W-1:0]         floor_mm = 24'd1;
  logic [FREQ_W-1:0]         carrier = 32'd28000000;
  logic                      full_turn = 1'b1;
  longint                    wgt_re [NCH];
  longint                    wgt_im [NCH];

  localparam longint ATAN_TABLE [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void rotate(input logic [31:0] ang, output longint c,
                                 output longint s);
    int     zi;
    longint z, x, y, dx, dy;
    bit     flip;
    zi = ang;
    z = zi;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1'b1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TABLE[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TABLE[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint scale_q30(input longint amp, input longint trig);
    longint v;
    v = (amp * trig + 64'sd536870912) >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic void rebuild_weights();
    longint unsigned fl, r, den, q, mag, tb;
    longint amp, ct, st, pc, ps, prod;
    logic [31:0] theta;
    fl = (floor_mm != 0) ? floor_mm : 1;
    r = (path_mm > fl) ? path_mm : fl;
    amp = 0;
    if (carrier != 0) begin
      den = 4 * longint'(carrier) * r;
      q = (64'd102463857147744204 + den / 2) / den;
      amp = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    end
    mag = (angle_q88 < 0) ? longint'(-longint'(angle_q88)) : longint'(angle_q88);
    tb = ((mag << 21) + 22) / 45;
    if (angle_q88 < 0) tb = 64'd0 - tb;
    theta = tb[31:0];
    rotate(theta, ct, st);
    for (int k = 0; k < NCH; k++) begin
      prod = st * k * (full_turn ? 4 : 2);
      rotate(prod[31:0], pc, ps);
      wgt_re[k] = scale_q30(amp, pc);
      wgt_im[k] = scale_q30(amp, ps);
    end
  endfunction

  function automatic beam_sum_t combine(input samples_t it);
    longint re, im, a, b;
    beam_sum_t r;
    re = 0;
    im = 0;
    for (int k = 0; k < NCH; k++) begin
      a = it.s[2*k];
      b = it.s[2*k+1];
      re += wgt_re[k] * a - wgt_im[k] * b;
      im += wgt_re[k] * b + wgt_im[k] * a;
    end
    r.re = re[SUM_W-1:0];
    r.im = im[SUM_W-1:0];
    return r;
  endfunction

  task automatic report(input string what, input sum_t got, input sum_t want);
    $display("mismatch %s at cycle %0d: got %0d want %0d", what, cycles, got, want);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    logic     nv;
    samples_t nx;
    if (rst_ni) begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_sums.push_back(combine(pending_reqs[0]));
        void'(pending_reqs.pop_front());
        nv = 1'b0;
      end
      if (!nv && pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
        nv = 1'b1;
        nx = pending_reqs[0];
        in_ch.ch0_re <= nx.s[0]; in_ch.ch0_im <= nx.s[1];
        in_ch.ch1_re <= nx.s[2]; in_ch.ch1_im <= nx.s[3];
        in_ch.ch2_re <= nx.s[4]; in_ch.ch2_im <= nx.s[5];
        in_ch.ch3_re <= nx.s[6]; in_ch.ch3_im <= nx.s[7];
      end
      in_ch.valid <= nv;
    end
  end

  // result sink with random stalls and one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 400) begin
        out_ch.ready <= 1'b0;
        hold_left <= 400;
        hold_done <= 1'b1;
      end else begin
        out_ch.ready <= calm || $urandom_range(0, 99) >= 13;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    beam_sum_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (expected_sums.size() == 0) begin
        report("unexpected result", out_ch.sum_re, '0);
      end else begin
        want = expected_sums.pop_front();
        if (out_ch.sum_re !== want.re) report("sum_re", out_ch.sum_re, want.re);
        if (out_ch.sum_im !== want.im) report("sum_im", out_ch.sum_im, want.im);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_sums.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ANGLE: angle_q88 = val[ANGLE_W-1:0];
      REG_PATH:  path_mm = val[DIST_W-1:0];
      REG_FLOOR: floor_mm = val[DIST_W-1:0];
      REG_FREQ:  carrier = val;
      REG_TURN:  full_turn = val[0];
      default: ;
    endcase
    rebuild_weights();
  endtask

  task automatic set_all(input logic [31:0] ang, input logic [31:0] p,
                         input logic [31:0] f, input logic [31:0] c,
                         input logic [31:0] t);
    drain();
    apb_write(REG_ANGLE, ang);
    apb_write(REG_PATH, p);
    apb_write(REG_FLOOR, f);
    apb_write(REG_FREQ, c);
    apb_write(REG_TURN, t);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return '0;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic queue_random(input int n);
    samples_t it;
    repeat (n) begin
      foreach (it.s[j]) it.s[j] = pick_sample();
      pending_reqs.push_back(it);
    end
  endtask

  task automatic queue_fill(input sample_t v);
    samples_t it;
    foreach (it.s[j]) it.s[j] = v;
    pending_reqs.push_back(it);
  endtask

  initial begin
    samples_t it;
    in_ch.valid = 1'b0;
    in_ch.ch0_re = '0; in_ch.ch0_im = '0; in_ch.ch1_re = '0; in_ch.ch1_im = '0;
    in_ch.ch2_re = '0; in_ch.ch2_im = '0; in_ch.ch3_re = '0; in_ch.ch3_im = '0;
    out_ch.ready = 1'b0;
    rebuild_weights();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and one channel at a time
    queue_fill(16'sd32767);
    queue_fill(-16'sd32768);
    queue_fill('0);
    queue_fill(16'sd1);
    queue_fill(-16'sd1);
    for (int k = 0; k < NCH; k++) begin
      foreach (it.s[j]) it.s[j] = '0;
      it.s[2*k] = 16'sd32767;
      pending_reqs.push_back(it);
      foreach (it.s[j]) it.s[j] = '0;
      it.s[2*k+1] = -16'sd32768;
      pending_reqs.push_back(it);
    end
    foreach (it.s[j]) it.s[j] = j[0] ? -16'sd32768 : 16'sd32767;
    pending_reqs.push_back(it);
    foreach (it.s[j]) it.s[j] = j[0] ? 16'sd21845 : -16'sd21846;
    pending_reqs.push_back(it);
    queue_random(PHASE_REQS);

    // saturating amplitude, steepest positive angle, half-turn spacing
    set_all(32'd46080, 32'd1, 32'd1, 32'd1, 32'd0);
    queue_random(PHASE_REQS);
    // far target at top carrier, steepest negative angle
    set_all(32'h1_4C00, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    queue_random(PHASE_REQS);
    // zero carrier gives zero weights; stray register address ignored
    set_all(32'd3000, 32'd500, 32'd10, 32'd0, 32'd1);
    apb_write(5, 32'hDEAD_BEEF);
    queue_random(60);
    // zero distance and zero floor, angle bits beyond the nominal range
    set_all(32'h1_0000, 32'd0, 32'd0, 32'd60000000, 32'd0);
    queue_random(PHASE_REQS);
    // floor above path distance, a stretch with no idling
    set_all(32'h0_FFFF, 32'd20, 32'd5000, 32'd77000000, 32'd1);
    calm = 1'b1;
    queue_random(PHASE_REQS);
    drain();
    calm = 1'b0;
    for (int p = 0; p < 5; p++) begin
      set_all($urandom_range(0, 32'h1_FFFF), $urandom_range(1, 32'hFF_FFFF) >> $urandom_range(0, 23),
              $urandom_range(1, 3000), $urandom() >> $urandom_range(0, 16),
              $urandom_range(0, 1));
      queue_random(PHASE_REQS);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
